// ===== sv/sha1mh_pkg.sv =====
`default_nettype none

package sha1mh_pkg;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LEN,
      ST_LOAD,
      ST_ROUND,
      ST_ADD,
      ST_EMIT
   } state_type;

   // what happens once the running compression is done
   typedef enum logic [1:0] {
      FOLLOW_IDLE,
      FOLLOW_PAD,
      FOLLOW_LEN,
      FOLLOW_EMIT
   } follow_type;

   // commands from controller to datapath
   typedef struct packed {
      logic       load_byte;
      logic       pad;
      logic       len;
      logic       start;
      logic       round;
      logic [1:0] round_grp;
      logic       add;
      logic       clear;
      logic [2:0] word_sel;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic blk_full;
      logic pad_two;
   } status_type;

   localparam logic [6:0] ROUND_LAST    = 7'd79;
   localparam logic [2:0] LAST_WORD_IDX = 3'd4;

   localparam logic [31:0] INIT_WORDS [5] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
   };

   localparam logic [31:0] ROUND_K [4] = '{
      32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'hca62c1d6
   };

endpackage

`default_nettype wire

// ===== sv/sha1mh_if.sv =====
`default_nettype none

// message byte channel
interface sha1mh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       last_byte;

   modport source(output valid, output data_byte, output has_byte, output last_byte,
                  input ready);
   modport sink(input valid, input data_byte, input has_byte, input last_byte,
                output ready);
endinterface

// digest word channel
interface sha1mh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic        last_word;

   modport source(output valid, output digest_word, output last_word, input ready);
   modport sink(input valid, input digest_word, input last_word, output ready);
endinterface

`default_nettype wire

// ===== sv/sha1mh_datapath.sv =====
`default_nettype none

module sha1mh_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [7:0]           data_byte,
   input  wire sha1mh_pkg::cmd_type  cmd,
   output sha1mh_pkg::status_type    status,
   output logic [31:0]               digest_word
);
   import sha1mh_pkg::*;

   logic [60:0] count_ff, count_in;
   logic [31:0] chain_ff [5];
   logic [31:0] chain_in [5];
   logic [31:0] blk_ff [16];
   logic [31:0] blk_in [16];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] a_in, b_in, c_in, d_in, e_in;

   logic [5:0]  pos;
   logic [4:0]  byte_sh;
   logic [4:0]  pad_sh;
   logic [63:0] bit_len;
   logic [31:0] f_val;
   logic [31:0] t_val;
   logic [31:0] w_next;

   assign pos     = count_ff[5:0];
   assign byte_sh = {~pos[1:0], 3'b000};
   assign pad_sh  = {pos[1:0], 3'b000};
   assign bit_len = {count_ff, 3'b000};

   assign status.blk_full = (pos == 6'd63);
   assign status.pad_two  = (pos >= 6'd56);

   // round function
   always_comb begin
      case (cmd.round_grp)
         2'd0:    f_val = (b_ff & c_ff) | (d_ff & ~b_ff);
         2'd2:    f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         default: f_val = b_ff ^ c_ff ^ d_ff;
      endcase
   end

   assign t_val  = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + blk_ff[0]
                 + ROUND_K[cmd.round_grp];
   assign w_next = {blk_ff[13][30:0] ^ blk_ff[8][30:0] ^ blk_ff[2][30:0] ^ blk_ff[0][30:0],
                    blk_ff[13][31] ^ blk_ff[8][31] ^ blk_ff[2][31] ^ blk_ff[0][31]};

   // next values of all storage
   always_comb begin
      count_in = count_ff;
      chain_in = chain_ff;
      blk_in   = blk_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      e_in     = e_ff;

      // byte insert, big-endian within the word
      if (cmd.load_byte) begin
         blk_in[pos[5:2]] = (blk_ff[pos[5:2]] & ~(32'h000000ff << byte_sh))
                          | ({24'd0, data_byte} << byte_sh);
         count_in = count_ff + 61'd1;
      end

      // 0x80 marker, zero fill, and length when it fits
      if (cmd.pad) begin
         for (int j = 0; j < 16; j++) begin
            if (4'(j) == pos[5:2]) begin
               blk_in[j] = (blk_ff[j] & ~(32'hffffffff >> pad_sh))
                         | (32'h80000000 >> pad_sh);
            end else if (4'(j) > pos[5:2]) begin
               blk_in[j] = 32'd0;
            end
         end
         if (!status.pad_two) begin
            blk_in[14] = bit_len[63:32];
            blk_in[15] = bit_len[31:0];
         end
      end

      // extra length-only block
      if (cmd.len) begin
         for (int j = 0; j < 14; j++) begin
            blk_in[j] = 32'd0;
         end
         blk_in[14] = bit_len[63:32];
         blk_in[15] = bit_len[31:0];
      end

      if (cmd.start) begin
         a_in = chain_ff[0];
         b_in = chain_ff[1];
         c_in = chain_ff[2];
         d_in = chain_ff[3];
         e_in = chain_ff[4];
      end

      // one round, schedule shifts down by one word
      if (cmd.round) begin
         a_in = t_val;
         b_in = a_ff;
         c_in = {b_ff[1:0], b_ff[31:2]};
         d_in = c_ff;
         e_in = d_ff;
         for (int j = 0; j < 15; j++) begin
            blk_in[j] = blk_ff[j + 1];
         end
         blk_in[15] = w_next;
      end

      if (cmd.add) begin
         chain_in[0] = chain_ff[0] + a_ff;
         chain_in[1] = chain_ff[1] + b_ff;
         chain_in[2] = chain_ff[2] + c_ff;
         chain_in[3] = chain_ff[3] + d_ff;
         chain_in[4] = chain_ff[4] + e_ff;
      end

      if (cmd.clear) begin
         chain_in = INIT_WORDS;
         count_in = 61'd0;
      end
   end

   // chaining words and count
   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= INIT_WORDS;
         count_ff <= 61'd0;
      end else begin
         chain_ff <= chain_in;
         count_ff <= count_in;
      end
   end

   // block and working words
   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      e_ff   <= e_in;
   end

   // digest word select
   always_comb begin
      case (cmd.word_sel)
         3'd1:    digest_word = chain_ff[1];
         3'd2:    digest_word = chain_ff[2];
         3'd3:    digest_word = chain_ff[3];
         3'd4:    digest_word = chain_ff[4];
         default: digest_word = chain_ff[0];
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/sha1mh_controller.sv =====
`default_nettype none

module sha1mh_controller (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_has,
   input  wire logic                    req_last,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic                         last_word,
   input  wire sha1mh_pkg::status_type  status,
   output sha1mh_pkg::cmd_type          cmd
);
   import sha1mh_pkg::*;

   state_type  state_ff, state_in;
   follow_type follow_ff, follow_in;
   logic [6:0] round_ff, round_in;
   logic [2:0] word_ff, word_in;

   // next state
   always_comb begin
      state_in  = state_ff;
      follow_in = follow_ff;
      round_in  = round_ff;
      word_in   = word_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_has && status.blk_full) begin
                  follow_in = req_last ? FOLLOW_PAD : FOLLOW_IDLE;
                  state_in  = ST_LOAD;
               end else if (req_last) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            follow_in = status.pad_two ? FOLLOW_LEN : FOLLOW_EMIT;
            state_in  = ST_LOAD;
         end
         ST_LEN: begin
            follow_in = FOLLOW_EMIT;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            round_in = 7'd0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            round_in = round_ff + 7'd1;
            if (round_ff == ROUND_LAST) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            unique case (follow_ff)
               FOLLOW_IDLE: state_in = ST_IDLE;
               FOLLOW_PAD:  state_in = ST_PAD;
               FOLLOW_LEN:  state_in = ST_LEN;
               FOLLOW_EMIT: begin
                  word_in  = 3'd0;
                  state_in = ST_EMIT;
               end
               default:     state_in = ST_IDLE;
            endcase
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               word_in = word_ff + 3'd1;
               if (word_ff == LAST_WORD_IDX) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath commands
   always_comb begin
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      cmd           = '0;
      cmd.word_sel  = word_ff;
      if (round_ff < 7'd20) begin
         cmd.round_grp = 2'd0;
      end else if (round_ff < 7'd40) begin
         cmd.round_grp = 2'd1;
      end else if (round_ff < 7'd60) begin
         cmd.round_grp = 2'd2;
      end else begin
         cmd.round_grp = 2'd3;
      end
      unique case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_byte = req_valid && req_has;
         end
         ST_PAD:   cmd.pad   = 1'b1;
         ST_LEN:   cmd.len   = 1'b1;
         ST_LOAD:  cmd.start = 1'b1;
         ST_ROUND: cmd.round = 1'b1;
         ST_ADD:   cmd.add   = 1'b1;
         ST_EMIT: begin
            rsp_valid = 1'b1;
            cmd.clear = rsp_ready && (word_ff == LAST_WORD_IDX);
         end
         default: ;
      endcase
   end

   assign last_word = (word_ff == LAST_WORD_IDX);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         follow_ff <= FOLLOW_IDLE;
         round_ff  <= 7'd0;
         word_ff   <= 3'd0;
      end else begin
         state_ff  <= state_in;
         follow_ff <= follow_in;
         round_ff  <= round_in;
         word_ff   <= word_in;
      end
   end

   // no byte is taken while a digest is being delivered
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken during digest delivery");

   // round counter stays within the 80 rounds
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (round_ff <= ROUND_LAST))
      else $error("round counter out of range");

   // final compression leads to delivery starting at word 0
   a_emit_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD && follow_ff == FOLLOW_EMIT) |=>
      (state_ff == ST_EMIT && word_ff == 3'd0))
      else $error("digest delivery did not start at word 0");

   // delivery ends after the fifth word
   a_emit_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && word_ff == LAST_WORD_IDX && rsp_ready) |=>
      (state_ff == ST_IDLE))
      else $error("digest delivery did not end after the last word");

   // word index never passes the last word while delivering
   a_word_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (word_ff <= LAST_WORD_IDX))
      else $error("digest word index out of range");

endmodule

`default_nettype wire

// ===== sv/sha1_message_hash_unit.sv =====
`default_nettype none

// channel   dir   fields                                  transfer when
// req_port  in    data_byte[8] has_byte[1] last_byte[1]   valid && ready
// rsp_port  out   digest_word[32] last_word[1]             valid && ready
//
// a byte that does not fill the block is simply stored; a full block adds a
// compression (load, 80 rounds of the single round unit, chaining add)
// a message end adds a pad step and one compression, or two compressions
// plus a length step when the length no longer fits, then five digest words
// reset is synchronous and restores the initial chaining words and zero count
// input is held off while compressing or delivering; rsp stalls hold the word

module sha1_message_hash_unit (
   input  wire logic     clock,
   input  wire logic     reset,
   sha1mh_req_if.sink    req_port,
   sha1mh_rsp_if.source  rsp_port
);
   import sha1mh_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencing of bytes, padding, rounds and digest output
   sha1mh_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_has   (req_port.has_byte),
      .req_last  (req_port.last_byte),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .last_word (rsp_port.last_word),
      .status    (status),
      .cmd       (cmd)
   );

   // block buffer, schedule, round unit and chaining words
   sha1mh_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .data_byte   (req_port.data_byte),
      .cmd         (cmd),
      .status      (status),
      .digest_word (rsp_port.digest_word)
   );

endmodule

`default_nettype wire

// ===== sim/sha1_message_hash_unit_tb.sv =====
`timescale 1ns / 1ps

module sha1_message_hash_unit_tb;

   localparam int CLK_PERIOD  = 10;
   localparam int RESET_CYCLES = 9;
   localparam int TIMEOUT_NS  = 2_000_000;
   localparam int MAX_REPORTS = 10;
   localparam int SETTLE_CYCLES = 200;

   localparam logic [31:0] IV_0 = 32'h67452301;
   localparam logic [31:0] IV_1 = 32'hefcdab89;
   localparam logic [31:0] IV_2 = 32'h98badcfe;
   localparam logic [31:0] IV_3 = 32'h10325476;
   localparam logic [31:0] IV_4 = 32'hc3d2e1f0;

   localparam logic [31:0] K_CHOOSE = 32'h5a827999;
   localparam logic [31:0] K_PARITY = 32'h6ed9eba1;
   localparam logic [31:0] K_MAJOR  = 32'h8f1bbcdc;
   localparam logic [31:0] K_TAIL   = 32'hca62c1d6;

   localparam logic [7:0] PAD_MARK = 8'h80;

   typedef struct {
      logic [31:0] word;
      logic        last;
   } digest_entry_type;

   logic clock = 1'b0;
   logic reset;

   sha1mh_req_if req_bus ();
   sha1mh_rsp_if rsp_bus ();

   sha1_message_hash_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   // hash state tracked alongside the block
   logic [31:0] chain_words [5];
   logic [31:0] block_buf [16];
   logic [60:0] byte_count;

   digest_entry_type expected_digest_q [$];
   digest_entry_type got_entry;

   int error_count   = 0;
   int req_idle_pct  = 0;
   int rsp_idle_pct  = 0;
   int rsp_hold_left = 0;
   int boundary_ptr  = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic logic [31:0] rotl(logic [31:0] x, int unsigned n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic void restart_hash();
      chain_words[0] = IV_0;
      chain_words[1] = IV_1;
      chain_words[2] = IV_2;
      chain_words[3] = IV_3;
      chain_words[4] = IV_4;
      byte_count     = '0;
   endfunction

   // one 80-round compression of block_buf into the chaining words
   function automatic void compress_block();
      logic [31:0] sched [80];
      logic [31:0] a, b, c, d, e, mix, rc, sum;
      for (int i = 0; i < 16; i++) sched[i] = block_buf[i];
      for (int i = 16; i < 80; i++)
         sched[i] = rotl(sched[i-3] ^ sched[i-8] ^ sched[i-14] ^ sched[i-16], 1);
      a = chain_words[0];
      b = chain_words[1];
      c = chain_words[2];
      d = chain_words[3];
      e = chain_words[4];
      for (int i = 0; i < 80; i++) begin
         if (i < 20) begin
            mix = (b & c) | (d & ~b);
            rc  = K_CHOOSE;
         end else if (i < 40) begin
            mix = b ^ c ^ d;
            rc  = K_PARITY;
         end else if (i < 60) begin
            mix = (b & c) | (b & d) | (c & d);
            rc  = K_MAJOR;
         end else begin
            mix = b ^ c ^ d;
            rc  = K_TAIL;
         end
         sum = rotl(a, 5) + mix + e + sched[i] + rc;
         e = d;
         d = c;
         c = rotl(b, 30);
         b = a;
         a = sum;
      end
      chain_words[0] += a;
      chain_words[1] += b;
      chain_words[2] += c;
      chain_words[3] += d;
      chain_words[4] += e;
   endfunction

   // big-endian byte placement inside the 16-word block
   function automatic void put_byte(logic [5:0] pos, logic [7:0] v);
      block_buf[pos[5:2]][8 * (3 - int'(pos[1:0])) +: 8] = v;
   endfunction

   // advance the hash by one accepted item, queue the digest on a message end
   function automatic void hash_accepted_item(logic [7:0] data_byte, logic has_byte,
                                              logic last_byte);
      logic [5:0]  pos;
      logic [63:0] bit_len;
      digest_entry_type entry;
      if (has_byte) begin
         pos = byte_count[5:0];
         put_byte(pos, data_byte);
         byte_count = byte_count + 61'd1;
         if (pos == 6'd63) compress_block();
      end
      if (last_byte) begin
         pos = byte_count[5:0];
         put_byte(pos, PAD_MARK);
         for (int i = int'(pos) + 1; i < 64; i++) put_byte(6'(i), 8'h00);
         // length no longer fits: flush and pad into a fresh block
         if (pos >= 6'd56) begin
            compress_block();
            block_buf = '{default: '0};
         end
         bit_len = {byte_count, 3'b000};
         block_buf[14] = bit_len[63:32];
         block_buf[15] = bit_len[31:0];
         compress_block();
         for (int k = 0; k < 5; k++) begin
            entry.word = chain_words[k];
            entry.last = (k == 4);
            expected_digest_q.push_back(entry);
         end
         restart_hash();
      end
   endfunction

   function automatic void note_mismatch(string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
   endfunction

   // track every accepted input transfer
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready)
         hash_accepted_item(req_bus.data_byte, req_bus.has_byte, req_bus.last_byte);
   end

   // result side: check each transfer, then pick ready for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_digest_q.size() == 0) begin
            note_mismatch($sformatf("digest word %h with nothing expected",
                                    rsp_bus.digest_word));
         end else begin
            got_entry = expected_digest_q.pop_front();
            if (rsp_bus.digest_word !== got_entry.word)
               note_mismatch($sformatf("digest_word expected %h, got %h",
                                       got_entry.word, rsp_bus.digest_word));
            if (rsp_bus.last_word !== got_entry.last)
               note_mismatch($sformatf("last_word expected %b, got %b",
                                       got_entry.last, rsp_bus.last_word));
         end
      end
      // long hold-off counted here, otherwise random stalls
      if (rsp_hold_left > 0) begin
         rsp_hold_left = rsp_hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // offer one item and wait for its transfer; valid stays up afterwards
   task automatic send_msg_item(input logic [7:0] data_byte, input logic has_byte,
                                input logic last_byte);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= data_byte;
      req_bus.has_byte  <= has_byte;
      req_bus.last_byte <= last_byte;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // a message of random bytes, with idle noise and sometimes an end marker
   task automatic send_random_message(input int msg_len);
      bit use_marker;
      use_marker = (msg_len == 0) || ($urandom_range(3) == 0);
      for (int i = 0; i < msg_len; i++) begin
         if ($urandom_range(9) == 0) send_msg_item(8'($urandom_range(255)), 1'b0, 1'b0);
         send_msg_item(8'($urandom_range(255)), 1'b1,
                       (i == msg_len - 1) && !use_marker);
      end
      if (use_marker) send_msg_item(8'($urandom_range(255)), 1'b0, 1'b1);
   endtask

   // stop offering, then wait until every queued digest word has arrived
   task automatic wait_for_digests();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_digest_q.size() != 0) @(posedge clock);
   endtask

   // empty message, short strings, idle items, byte extremes
   task automatic test_short_messages();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      send_msg_item(8'ha5, 1'b0, 1'b1);
      send_msg_item(8'h61, 1'b1, 1'b0);
      send_msg_item(8'h62, 1'b1, 1'b0);
      send_msg_item(8'hff, 1'b0, 1'b0);
      send_msg_item(8'h63, 1'b1, 1'b1);
      send_msg_item(8'h00, 1'b1, 1'b1);
      send_msg_item(8'hff, 1'b1, 1'b1);
      send_msg_item(8'hff, 1'b1, 1'b0);
      send_msg_item(8'h00, 1'b1, 1'b0);
      send_msg_item(8'h5a, 1'b0, 1'b1);
      send_msg_item(8'h3c, 1'b0, 1'b0);
      send_msg_item(8'hc3, 1'b0, 1'b0);
      send_msg_item(8'h80, 1'b1, 1'b1);
      wait_for_digests();
   endtask

   // random messages; the first of each phase and some others sit at block edges
   task automatic test_random_messages(input int req_gap_pct, input int rsp_gap_pct,
                                       input int item_target);
      int sent;
      int msg_len;
      bit first_msg;
      req_idle_pct = req_gap_pct;
      rsp_idle_pct = rsp_gap_pct;
      sent      = 0;
      first_msg = 1'b1;
      while (sent < item_target) begin
         if (first_msg || $urandom_range(99) < 20) begin
            // full block then last, length spilling over, exact fit, one short
            case (boundary_ptr)
               0: msg_len = 64;
               1: msg_len = 56;
               2: msg_len = 55;
               default: msg_len = 63;
            endcase
            boundary_ptr = (boundary_ptr + 1) % 4;
         end else begin
            msg_len = $urandom_range(10);
         end
         first_msg = 1'b0;
         send_random_message(msg_len);
         sent += msg_len + 1;
      end
      wait_for_digests();
   endtask

   // receiver stalls for a long stretch while the sender keeps pushing
   task automatic test_output_backpressure();
      req_idle_pct  = 0;
      rsp_idle_pct  = 0;
      rsp_hold_left = 400;
      for (int m = 0; m < 3; m++) send_random_message(4);
      wait_for_digests();
   endtask

   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = '0;
      req_bus.has_byte  = 1'b0;
      req_bus.last_byte = 1'b0;
      rsp_bus.ready     = 1'b0;
      restart_hash();
      block_buf = '{default: '0};
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_short_messages();
      test_random_messages(17, 46, 60);
      test_random_messages(46, 17, 60);
      test_random_messages(0, 0, 60);
      test_output_backpressure();

      wait_for_digests();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_digest_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(TIMEOUT_NS);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/sha1mh_pkg.sv
sv/sha1mh_if.sv
sv/sha1mh_datapath.sv
sv/sha1mh_controller.sv
sv/sha1_message_hash_unit.sv
sim/sha1_message_hash_unit_tb.sv
